/* rtl/hed_pkg.sv */
// Shared types, constants and helper functions of the character reference decoder.
package hed_pkg;

  // Default lookahead after an opening ampersand
  localparam int LOOKAHEAD_DEPTH_DEF = 10;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 12;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 12'hFFF;
  localparam logic [LEN_W-1:0] CNT_MAX        = 12'hFFF;

  // Register index, taken from paddr[2]
  localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

  typedef logic [7:0]       byte_t;
  typedef logic [LEN_W-1:0] len_t;

  // Characters of interest
  localparam byte_t CH_AMP  = 8'h26;  // &
  localparam byte_t CH_SEMI = 8'h3B;  // ;
  localparam byte_t CH_HASH = 8'h23;  // #
  localparam byte_t CH_LX   = 8'h78;  // x
  localparam byte_t CH_UX   = 8'h58;  // X
  localparam byte_t CH_0    = 8'h30;
  localparam byte_t CH_9    = 8'h39;
  localparam byte_t CH_LA   = 8'h61;
  localparam byte_t CH_LF   = 8'h66;
  localparam byte_t CH_UA   = 8'h41;
  localparam byte_t CH_UZ   = 8'h5A;
  localparam byte_t HEX_BIAS = 8'h57; // 'a' - 10
  localparam logic [10:0] NUM_LIMIT = 11'd127;

  // Named references
  typedef enum logic [2:0] {
    RN_AMP,
    RN_QUOT,
    RN_APOS,
    RN_LT,
    RN_GT
  } ref_name_t;
  localparam int NUM_NAMES = 5;

  // Engine operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FRESH,
    OP_REPLAY,
    OP_FLUSH_AMP,
    OP_FLUSH_TEXT,
    OP_FINISH
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REPLAY,
    S_FLUSH_AMP,
    S_FLUSH_TEXT,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t  op;
    logic fresh;      // byte comes from the input channel, not the buffer
  } cmd_t;

  typedef struct packed {
    logic fail;       // open reference fails on this byte
    logic ref_open;   // a reference is open after this byte
    logic replay_end; // read pointer sits on the last byte to scan or flush
    logic pend_empty; // no held bytes
    logic out_free;   // output register can take a byte this cycle
    logic last;       // the item being worked on ends its string
    logic in_ref;
    logic hold_valid;
  } sts_t;

  function automatic byte_t to_lower(byte_t c);
    return (c >= CH_UA && c <= CH_UZ) ? byte_t'(c + 8'd32) : c;
  endfunction

  function automatic logic [2:0] ref_name_len(ref_name_t id);
    logic [2:0] len;
    unique case (id)
      RN_AMP:  len = 3'd3;
      RN_QUOT: len = 3'd4;
      RN_APOS: len = 3'd4;
      RN_LT:   len = 3'd2;
      RN_GT:   len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Lower-case spelling of each name, by position
  function automatic byte_t ref_name_char(ref_name_t id, logic [1:0] pos);
    byte_t c;
    c = 8'h00;
    unique case (id)
      RN_AMP: begin
        unique case (pos)
          2'd0: c = 8'h61;
          2'd1: c = 8'h6D;
          2'd2: c = 8'h70;
          default: c = 8'h00;
        endcase
      end
      RN_QUOT: begin
        unique case (pos)
          2'd0: c = 8'h71;
          2'd1: c = 8'h75;
          2'd2: c = 8'h6F;
          default: c = 8'h74;
        endcase
      end
      RN_APOS: begin
        unique case (pos)
          2'd0: c = 8'h61;
          2'd1: c = 8'h70;
          2'd2: c = 8'h6F;
          default: c = 8'h73;
        endcase
      end
      RN_LT: begin
        unique case (pos)
          2'd0: c = 8'h6C;
          2'd1: c = 8'h74;
          default: c = 8'h00;
        endcase
      end
      RN_GT: begin
        unique case (pos)
          2'd0: c = 8'h67;
          2'd1: c = 8'h74;
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic byte_t ref_name_value(ref_name_t id);
    byte_t v;
    unique case (id)
      RN_AMP:  v = 8'h26;
      RN_QUOT: v = 8'h22;
      RN_APOS: v = 8'h27;
      RN_LT:   v = 8'h3C;
      RN_GT:   v = 8'h3E;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

/* rtl/hed_if.sv */
// Input and output item channels of the character reference decoder.
interface hed_in_if;
  logic           valid;
  logic           ready;
  hed_pkg::byte_t in_char;
  logic           in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface hed_out_if;
  logic           valid;
  logic           ready;
  hed_pkg::byte_t out_char;
  logic           out_last;
  logic           out_overflow;

  modport source (output valid, out_char, out_last, out_overflow, input ready);
  modport sink   (input valid, out_char, out_last, out_overflow, output ready);
endinterface

/* rtl/html_entity_decoder.sv */
// Top level of the streaming HTML character reference decoder.
//
// Input channel inp carries one text byte per item with in_last on the final
// byte of a string; output channel outp carries decoded bytes with out_last
// on the final decoded byte and out_overflow on every byte at a position of
// max_length or beyond. max_length is written over the APB port at address 0.
// Plain text and successful references are accepted at one input item per
// cycle while the output register has room; the decoded byte sits in the
// output register the cycle after acceptance. A failed reference emits '&'
// and rescans the held bytes and the failing byte, one byte a cycle from the
// lookahead buffer while the output register has room. A failure met during
// the rescan starts a new pass over the bytes after its own '&'.
// The last item of a string keeps its final byte in a hold register and
// releases it with out_last in the finish state, after '&' and the held bytes
// are flushed literally when a reference is still open.
// While the receiver stalls and the output register is full, inp.ready is low
// and the engine waits. Reset clears the controller and scan state and the
// byte count, drops both valid flags and returns max_length to 4095.
module html_entity_decoder #(
  parameter int LOOKAHEAD_DEPTH = hed_pkg::LOOKAHEAD_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  hed_in_if.sink                     inp,
  hed_out_if.source                  outp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hed_pkg::ADDR_W-1:0] paddr,
  input  logic [hed_pkg::DATA_W-1:0] pwdata,
  output logic [hed_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import hed_pkg::*;

  len_t max_length;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2:2] == REG_MAX_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_length <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(DATA_W-LEN_W){1'b0}}, max_length} : '0;

  assign inp.ready = in_ready;

  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (inp.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  hed_datapath #(
    .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .max_length   (max_length),
    .in_char      (inp.in_char),
    .in_last      (inp.in_last),
    .out_ready    (outp.ready),
    .out_valid    (outp.valid),
    .out_char     (outp.out_char),
    .out_last     (outp.out_last),
    .out_overflow (outp.out_overflow),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

/* rtl/hed_datapath.sv */
// Datapath: lookahead buffer, incremental reference matcher, hold and output registers.
module hed_datapath #(
  parameter int LOOKAHEAD_DEPTH = hed_pkg::LOOKAHEAD_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  hed_pkg::len_t  max_length,
  input  hed_pkg::byte_t in_char,
  input  logic           in_last,
  input  logic           out_ready,
  output logic           out_valid,
  output hed_pkg::byte_t out_char,
  output logic           out_last,
  output logic           out_overflow,
  input  hed_pkg::cmd_t  cmd,
  output hed_pkg::sts_t  sts
);
  import hed_pkg::*;

  localparam int IW = $clog2(LOOKAHEAD_DEPTH);
  localparam logic [IW:0]   DEPTH    = (IW+1)'(LOOKAHEAD_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(LOOKAHEAD_DEPTH - 1);

  // Held bytes sit in a circular window starting at base
  byte_t         buffer [LOOKAHEAD_DEPTH];
  logic [IW-1:0] base;
  logic [IW-1:0] pc;
  logic [IW-1:0] rp;
  logic [IW-1:0] rend;
  logic          in_ref;

  // Incremental match state of the open reference
  logic [NUM_NAMES-1:0] nm;
  logic                 num_ok;
  logic                 num_hex;
  logic                 num_dig;
  logic [6:0]           acc;

  logic  step_last;
  logic  hold_valid;
  byte_t hold_char;
  logic  hold_ovf;
  len_t  emitted_count;

  function automatic logic [IW-1:0] ptr_inc(logic [IW-1:0] x);
    return (x == LAST_IDX) ? '0 : x + 1'b1;
  endfunction

  byte_t                cur;
  byte_t                lc;
  logic [IW:0]          wsum;
  logic [IW-1:0]        wpos;
  logic [IW-1:0]        wpos_m1;
  logic                 eff_last;
  logic                 out_free;
  logic                 is_proc;

  logic                 name_hit;
  byte_t                name_val;
  logic                 dec_ok;
  byte_t                dec_val;

  logic [NUM_NAMES-1:0] nm_upd;
  logic                 dig_dec;
  logic                 dig_hex;
  logic [3:0]           dig_val;
  logic [10:0]          acc_mul;
  logic [10:0]          acc_new;
  logic                 num_ok_upd;
  logic                 num_hex_upd;
  logic                 num_dig_upd;
  logic [6:0]           acc_upd;

  logic                 p_emit;
  byte_t                p_char;
  logic                 p_fail;
  logic                 p_open;
  logic                 p_close;
  logic                 p_append;

  logic                 emit_ev;
  byte_t                emit_ch;
  logic                 ovf;
  logic                 buf_we;

  // Byte selection and window arithmetic
  always_comb begin
    cur      = cmd.fresh ? in_char : buffer[rp];
    lc       = to_lower(cur);
    wsum     = {1'b0, base} + {1'b0, pc};
    wpos     = (wsum >= DEPTH) ? IW'(wsum - DEPTH) : wsum[IW-1:0];
    wpos_m1  = (wpos == '0) ? LAST_IDX : wpos - 1'b1;
    eff_last = cmd.fresh ? in_last : step_last;
    out_free = !out_valid || out_ready;
    is_proc  = (cmd.op == OP_FRESH) || (cmd.op == OP_REPLAY);
  end

  // Result of a ';' given the bytes held so far
  always_comb begin
    name_hit = 1'b0;
    name_val = '0;
    for (int k = 0; k < NUM_NAMES; k++) begin
      if (nm[k] && pc == IW'(ref_name_len(ref_name_t'(k)))) begin
        name_hit = 1'b1;
        name_val = ref_name_value(ref_name_t'(k));
      end
    end
    dec_ok  = name_hit || (num_ok && num_dig);
    dec_val = name_hit ? name_val : {1'b0, acc};
  end

  // Matcher update when a byte joins the held text at position pc
  always_comb begin
    for (int k = 0; k < NUM_NAMES; k++) begin
      nm_upd[k] = nm[k] && (pc < IW'(ref_name_len(ref_name_t'(k)))) &&
                  (lc == ref_name_char(ref_name_t'(k), pc[1:0]));
    end
    dig_dec = (lc >= CH_0) && (lc <= CH_9);
    dig_hex = num_hex && (lc >= CH_LA) && (lc <= CH_LF);
    dig_val = dig_dec ? 4'(lc - CH_0) : 4'(lc - HEX_BIAS);
    acc_mul = num_hex ? {acc, 4'b0000}
                      : ({1'b0, acc, 3'b000} + {3'b000, acc, 1'b0});
    acc_new = acc_mul + {7'b0, dig_val};

    num_ok_upd  = num_ok;
    num_hex_upd = num_hex;
    num_dig_upd = num_dig;
    acc_upd     = acc;
    priority if (pc == '0) begin
      num_ok_upd  = (cur == CH_HASH);
      num_hex_upd = 1'b0;
      num_dig_upd = 1'b0;
      acc_upd     = '0;
    end else if (pc == IW'(1) && (cur == CH_LX || cur == CH_UX)) begin
      num_hex_upd = 1'b1;
    end else if (!(dig_dec || dig_hex) || acc_new > NUM_LIMIT) begin
      num_ok_upd = 1'b0;
    end else begin
      acc_upd     = acc_new[6:0];
      num_dig_upd = 1'b1;
    end
  end

  // What the scanned byte does
  always_comb begin
    p_emit   = 1'b0;
    p_char   = cur;
    p_fail   = 1'b0;
    p_open   = 1'b0;
    p_close  = 1'b0;
    p_append = 1'b0;
    priority if (!in_ref) begin
      if (cur == CH_AMP) p_open = 1'b1;
      else               p_emit = 1'b1;
    end else if (cur == CH_SEMI) begin
      if (dec_ok) begin
        p_emit  = 1'b1;
        p_char  = dec_val;
        p_close = 1'b1;
      end else begin
        p_fail = 1'b1;
      end
    end else if (pc == LAST_IDX) begin
      p_fail = 1'b1;
    end else begin
      p_append = 1'b1;
    end
    if (p_fail) begin
      p_emit = 1'b1;
      p_char = CH_AMP;
    end
  end

  // Emission select
  always_comb begin
    emit_ev = (is_proc && p_emit) || (cmd.op == OP_FLUSH_AMP) ||
              (cmd.op == OP_FLUSH_TEXT);
    if (is_proc)                    emit_ch = p_char;
    else if (cmd.op == OP_FLUSH_AMP) emit_ch = CH_AMP;
    else                             emit_ch = buffer[rp];
    ovf    = (emitted_count >= max_length);
    buf_we = (cmd.op == OP_FRESH) && (p_append || p_fail);
  end

  // Status to the controller
  always_comb begin
    sts.fail       = p_fail;
    sts.ref_open   = p_open || p_append;
    sts.replay_end = (rp == rend);
    sts.pend_empty = (pc == '0);
    sts.out_free   = out_free;
    sts.last       = eff_last;
    sts.in_ref     = in_ref;
    sts.hold_valid = hold_valid;
  end

  // Lookahead buffer
  always_ff @(posedge clk) begin
    if (buf_we) buffer[wpos] <= cur;
  end

  // Scan control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_ref    <= 1'b0;
      pc        <= '0;
      base      <= '0;
      rp        <= '0;
      rend      <= '0;
      step_last <= 1'b0;
    end else begin
      if (cmd.op == OP_FRESH) step_last <= in_last;
      if (is_proc) begin
        if (p_open) begin
          in_ref <= 1'b1;
          pc     <= '0;
          if (!cmd.fresh) base <= ptr_inc(rp);
        end
        if (p_close) begin
          in_ref <= 1'b0;
          pc     <= '0;
        end
        if (p_append) pc <= pc + 1'b1;
        if (p_fail) begin
          in_ref <= 1'b0;
          pc     <= '0;
          rp     <= base;
          if (cmd.fresh) rend <= wpos;
        end else if (cmd.op == OP_REPLAY) begin
          rp <= ptr_inc(rp);
        end
      end
      unique case (cmd.op)
        OP_FLUSH_AMP: begin
          rp   <= base;
          rend <= wpos_m1;
        end
        OP_FLUSH_TEXT: rp <= ptr_inc(rp);
        OP_FINISH: begin
          in_ref <= 1'b0;
          pc     <= '0;
        end
        default: ;
      endcase
    end
  end

  // Matcher registers
  always_ff @(posedge clk) begin
    if (is_proc && p_open) begin
      nm      <= '1;
      num_ok  <= 1'b0;
      num_hex <= 1'b0;
      num_dig <= 1'b0;
      acc     <= '0;
    end else if (is_proc && p_append) begin
      nm      <= nm_upd;
      num_ok  <= num_ok_upd;
      num_hex <= num_hex_upd;
      num_dig <= num_dig_upd;
      acc     <= acc_upd;
    end
  end

  // Output and hold valid flags, byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      hold_valid    <= 1'b0;
      emitted_count <= '0;
    end else if (emit_ev) begin
      if (emitted_count != CNT_MAX) emitted_count <= emitted_count + 1'b1;
      if (eff_last) begin
        if (hold_valid)     out_valid <= 1'b1;
        else if (out_ready) out_valid <= 1'b0;
        hold_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (cmd.op == OP_FINISH) begin
      out_valid     <= hold_valid;
      hold_valid    <= 1'b0;
      emitted_count <= '0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output and hold payload
  always_ff @(posedge clk) begin
    if (emit_ev) begin
      if (eff_last) begin
        if (hold_valid) begin
          out_char     <= hold_char;
          out_overflow <= hold_ovf;
          out_last     <= 1'b0;
        end
        hold_char <= emit_ch;
        hold_ovf  <= ovf;
      end else begin
        out_char     <= emit_ch;
        out_overflow <= ovf;
        out_last     <= 1'b0;
      end
    end else if (cmd.op == OP_FINISH) begin
      out_char     <= hold_char;
      out_overflow <= hold_ovf;
      out_last     <= 1'b1;
    end
  end

endmodule

/* rtl/hed_ctrl.sv */
// Controller: sequences fresh bytes, replays after a failed reference and end-of-string flush.
module hed_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output hed_pkg::cmd_t cmd,
  input  hed_pkg::sts_t sts
);
  import hed_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && sts.out_free) begin
          priority if (sts.fail) state_next = S_REPLAY;
          else if (sts.last)     state_next = sts.ref_open ? S_FLUSH_AMP : S_FINISH;
          else                   state_next = S_IDLE;
        end
      end
      S_REPLAY: begin
        if (sts.out_free) begin
          priority if (sts.fail) state_next = S_REPLAY;
          else if (sts.replay_end) begin
            if (sts.last) state_next = sts.ref_open ? S_FLUSH_AMP : S_FINISH;
            else          state_next = S_IDLE;
          end else begin
            state_next = S_REPLAY;
          end
        end
      end
      S_FLUSH_AMP: begin
        if (sts.out_free) state_next = sts.pend_empty ? S_FINISH : S_FLUSH_TEXT;
      end
      S_FLUSH_TEXT: begin
        if (sts.out_free && sts.replay_end) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: every operation waits for room in the output register
  always_comb begin
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.fresh = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) cmd.op = OP_FRESH;
      end
      S_REPLAY:     if (sts.out_free) cmd.op = OP_REPLAY;
      S_FLUSH_AMP:  if (sts.out_free) cmd.op = OP_FLUSH_AMP;
      S_FLUSH_TEXT: if (sts.out_free) cmd.op = OP_FLUSH_TEXT;
      S_FINISH:     if (sts.out_free) cmd.op = OP_FINISH;
      default:      cmd.op = OP_NONE;
    endcase
  end

  // The final byte of a string must be parked in the hold register
  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> sts.hold_valid)
    else $error("finish without a held byte");

  // Nothing may stay held between strings
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.hold_valid)
    else $error("held byte left over in idle");

  // Flush only runs on an open reference
  a_flush_ref: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH_AMP || state == S_FLUSH_TEXT) |-> sts.in_ref)
    else $error("flush without an open reference");

  // Closing a string leaves no reference open
  a_finish_close: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && sts.out_free) |=> (state == S_IDLE && !sts.in_ref))
    else $error("reference still open after end of string");

endmodule
